// File: design/pvdd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the varint delta sample decoder
// no dependencies

package pvdd_pkg;

  localparam int MaxCounters = 8;
  localparam int NumCols     = MaxCounters + 1;
  localparam int ColW        = $clog2(NumCols);
  localparam int ValW        = 64;
  localparam int PendW       = 4;
  localparam int LeadBits    = 6;
  localparam logic [LeadBits-1:0] LeadMask = 6'h3F;

  localparam int FifoDepth = 32;
  localparam int FifoAddrW = $clog2(FifoDepth);
  localparam int FifoPtrW  = FifoAddrW + 1;

  typedef enum logic [1:0] {
    CodeShort = 2'd0,
    CodeMid   = 2'd1,
    CodeLong  = 2'd2,
    CodeFull  = 2'd3
  } lead_code_e;

  typedef struct packed {
    logic [ColW-1:0] column;
    logic [ValW-1:0] value;
    logic            row_last;
  } fifo_entry_t;

  localparam int EntryW = $bits(fifo_entry_t);

  // push: a column result is written, drop: discard the unfinished row
  typedef struct packed {
    logic push;
    logic drop;
  } fifo_ctrl_t;

  function automatic logic [PendW-1:0] extra_bytes(input lead_code_e code);
    logic [PendW-1:0] n;
    unique case (code)
      CodeShort: n = 4'd0;
      CodeMid:   n = 4'd2;
      CodeLong:  n = 4'd3;
      CodeFull:  n = 4'd8;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// File: design/pvdd_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module pvdd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/pvdd_row_fifo.sv
`timescale 1ns / 1ps
// result buffer: column results are staged until their row is complete,
// then released to the output channel; uses pvdd_pkg and pvdd_ram

module pvdd_row_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pvdd_pkg::fifo_ctrl_t          ctrl_i,
  input  pvdd_pkg::fifo_entry_t         entry_i,
  output logic [pvdd_pkg::FifoPtrW-1:0] used_o,
  output logic                          valid_o,
  input  logic                          stall_i,
  output pvdd_pkg::fifo_entry_t         entry_o
);

  logic [pvdd_pkg::FifoPtrW-1:0] wr_q, wr_d;
  logic [pvdd_pkg::FifoPtrW-1:0] commit_q, commit_d;
  logic [pvdd_pkg::FifoPtrW-1:0] rd_q, rd_d;
  logic                          valid_q, valid_d;
  logic                          avail;
  logic                          re;
  logic [pvdd_pkg::EntryW-1:0]   wr_bits;
  logic [pvdd_pkg::EntryW-1:0]   rd_bits;

  always_comb begin
    wr_d     = wr_q;
    commit_d = commit_q;
    if (ctrl_i.drop) begin
      // a row finished in the same cycle still goes out
      if (ctrl_i.push && entry_i.row_last) begin
        wr_d     = wr_q + 1'b1;
        commit_d = wr_q + 1'b1;
      end else begin
        wr_d = commit_q;
      end
    end else if (ctrl_i.push) begin
      wr_d = wr_q + 1'b1;
      if (entry_i.row_last) begin
        commit_d = wr_q + 1'b1;
      end
    end
  end

  // ram read register doubles as the output register
  assign avail   = commit_q != rd_q;
  assign re      = avail && (!valid_q || !stall_i);
  assign rd_d    = re ? rd_q + 1'b1 : rd_q;
  assign valid_d = (!valid_q || !stall_i) ? avail : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q     <= '0;
      commit_q <= '0;
      rd_q     <= '0;
      valid_q  <= 1'b0;
    end else begin
      wr_q     <= wr_d;
      commit_q <= commit_d;
      rd_q     <= rd_d;
      valid_q  <= valid_d;
    end
  end

  assign wr_bits = entry_i;

  pvdd_ram #(
    .Width(pvdd_pkg::EntryW),
    .Depth(pvdd_pkg::FifoDepth)
  ) u_buf_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.push),
    .waddr_i(wr_q[pvdd_pkg::FifoAddrW-1:0]),
    .wdata_i(wr_bits),
    .re_i   (re),
    .raddr_i(rd_q[pvdd_pkg::FifoAddrW-1:0]),
    .rdata_o(rd_bits)
  );

  assign used_o  = wr_q - rd_q;
  assign valid_o = valid_q;
  assign entry_o = pvdd_pkg::fifo_entry_t'(rd_bits);

endmodule

// File: design/prefix_varint_delta_sample_decoder_core.sv
`timescale 1ns / 1ps
// top level of the varint delta sample decoder
// uses pvdd_pkg, pvdd_ram and pvdd_row_fifo
//
// Input channel: one byte of the encoded stream per transaction, with
// first_of_message marking the start of a message (clears column sums,
// column position and any partial delta, then the byte is decoded).
// Output channel: one transaction per column of a finished row, columns
// 0..counter_count (capped at 8) in order, row_last set on the final column.
// Configuration: cfg_we_i writes counter_count; write only while idle.
// Throughput: one input byte per cycle while in_stall_o is low. Each
// finished delta does one read-modify-write of the column sum memory
// (read, then add and write in the next cycle); consecutive deltas hit
// different columns, so no forwarding is needed. Results go into a
// 32-entry buffer. Result path: the results of a row pass the add stage,
// the buffer and its read register, one per cycle while not stalled.
// Stall: in_stall_o rises when the result buffer cannot take more; an
// output stall holds the result and after enough rows stalls the input.
// Reset: counter_count is zero (decoding off), sums read as zero, the
// buffer is empty; no clearing pass is needed.

module prefix_varint_delta_sample_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [3:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        first_of_message_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pvdd_pkg::ColW-1:0]   column_o,
  output logic [pvdd_pkg::ValW-1:0]   value_o,
  output logic                        row_last_o
);

  logic [3:0]                    cc_q;
  logic [pvdd_pkg::PendW-1:0]    pend_q, pend_d, pend_base;
  logic [pvdd_pkg::ValW-1:0]     pd_q, pd_d, pd_base;
  logic [pvdd_pkg::ColW-1:0]     ci_q, ci_d, ci_base;
  logic [pvdd_pkg::NumCols-1:0]  vld_q;

  logic                          s2_valid_q;
  logic [pvdd_pkg::ColW-1:0]     s2_col_q;
  logic [pvdd_pkg::ValW-1:0]     s2_delta_q;
  logic                          s2_last_q;
  logic                          s2_fresh_q;

  logic                          accept;
  logic                          clear;
  logic                          done;
  logic [pvdd_pkg::ValW-1:0]     delta;
  logic [pvdd_pkg::ColW-1:0]     last_col;
  logic [pvdd_pkg::ColW-1:0]     col;
  logic                          col_last;
  pvdd_pkg::lead_code_e          code;
  logic [pvdd_pkg::PendW-1:0]    extra;

  logic [pvdd_pkg::ValW-1:0]     sum_rdata;
  logic [pvdd_pkg::ValW-1:0]     s2_sum;
  logic [pvdd_pkg::FifoPtrW-1:0] used;
  logic [pvdd_pkg::FifoPtrW:0]   fill;
  pvdd_pkg::fifo_ctrl_t          fifo_ctrl;
  pvdd_pkg::fifo_entry_t         push_entry;
  pvdd_pkg::fifo_entry_t         out_entry;

  assign accept = in_valid_i && !in_stall_o;
  assign clear  = accept && first_of_message_i;

  // counters above the maximum act as the maximum
  assign last_col = (cc_q > 4'(pvdd_pkg::MaxCounters))
                    ? pvdd_pkg::ColW'(pvdd_pkg::MaxCounters)
                    : cc_q[pvdd_pkg::ColW-1:0];

  assign pend_base = first_of_message_i ? '0 : pend_q;
  assign pd_base   = first_of_message_i ? '0 : pd_q;
  assign ci_base   = first_of_message_i ? '0 : ci_q;
  assign col       = (ci_base > last_col) ? '0 : ci_base;
  assign col_last  = col == last_col;
  assign code      = pvdd_pkg::lead_code_e'(data_byte_i[7:6]);
  assign extra     = pvdd_pkg::extra_bytes(code);

  always_comb begin
    pend_d = pend_q;
    pd_d   = pd_q;
    ci_d   = ci_q;
    done   = 1'b0;
    delta  = '0;
    if (cfg_we_i) begin
      pend_d = '0;
      pd_d   = '0;
      ci_d   = '0;
    end else if (accept) begin
      pend_d = pend_base;
      pd_d   = pd_base;
      ci_d   = ci_base;
      if (cc_q != 4'd0) begin
        if (pend_base == '0) begin
          delta  = (code == pvdd_pkg::CodeFull) ? '0 :
                   {{(pvdd_pkg::ValW-pvdd_pkg::LeadBits){1'b0}},
                    data_byte_i[pvdd_pkg::LeadBits-1:0] & pvdd_pkg::LeadMask};
          pend_d = extra;
          done   = extra == '0;
        end else begin
          delta  = {pd_base[pvdd_pkg::ValW-9:0], data_byte_i};
          pend_d = pend_base - 1'b1;
          done   = pend_base == pvdd_pkg::PendW'(1);
        end
        pd_d = delta;
        if (done) begin
          pd_d = '0;
          ci_d = col_last ? '0 : col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q       <= '0;
      pend_q     <= '0;
      pd_q       <= '0;
      ci_q       <= '0;
      vld_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cc_q <= cfg_wdata_i;
      end
      pend_q     <= pend_d;
      pd_q       <= pd_d;
      ci_q       <= ci_d;
      s2_valid_q <= done;
      if (clear) begin
        vld_q <= '0;
      end else if (s2_valid_q) begin
        vld_q[s2_col_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      s2_col_q   <= col;
      s2_delta_q <= delta;
      s2_last_q  <= col_last;
      s2_fresh_q <= first_of_message_i || !vld_q[col];
    end
  end

  // sum memory read-modify-write, the read was issued with the last byte
  assign s2_sum = (s2_fresh_q ? '0 : sum_rdata) + s2_delta_q;

  pvdd_ram #(
    .Width(pvdd_pkg::ValW),
    .Depth(pvdd_pkg::NumCols)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (s2_valid_q && !clear),
    .waddr_i(s2_col_q),
    .wdata_i(s2_sum),
    .re_i   (done),
    .raddr_i(col),
    .rdata_o(sum_rdata)
  );

  assign fifo_ctrl.push      = s2_valid_q;
  assign fifo_ctrl.drop      = clear || cfg_we_i;
  assign push_entry.column   = s2_col_q;
  assign push_entry.value    = s2_sum;
  assign push_entry.row_last = s2_last_q;

  pvdd_row_fifo u_row_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fifo_ctrl),
    .entry_i(push_entry),
    .used_o (used),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .entry_o(out_entry)
  );

  // leave room for the result still in the add stage and the next one
  assign fill       = {1'b0, used} + {{pvdd_pkg::FifoPtrW{1'b0}}, s2_valid_q};
  assign in_stall_o = fill >= (pvdd_pkg::FifoPtrW + 1)'(pvdd_pkg::FifoDepth);

  assign column_o   = out_entry.column;
  assign value_o    = out_entry.value;
  assign row_last_o = out_entry.row_last;

endmodule

// File: design/pvdd_checker.sv
`timescale 1ns / 1ps
// port-level checks for the varint delta sample decoder, bound to the top
// uses pvdd_pkg

module pvdd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [pvdd_pkg::ColW-1:0]   column_o,
  input logic [pvdd_pkg::ValW-1:0]   value_o,
  input logic                        row_last_o
);

  logic                      out_xfer;
  logic [pvdd_pkg::ColW-1:0] exp_col_q;

  assign out_xfer = out_valid_o && !out_stall_i;

  // column expected in the next output transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_col_q <= '0;
    end else if (out_xfer) begin
      exp_col_q <= row_last_o ? '0 : column_o + 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(column_o))
    else $error("output changed while stalled");

  a_col_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> column_o == exp_col_q)
    else $error("row columns out of order");

  a_row_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_last_o |-> column_o != '0)
    else $error("row with a single column");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> column_o <= pvdd_pkg::ColW'(pvdd_pkg::MaxCounters))
    else $error("column beyond the last counter");

endmodule

bind prefix_varint_delta_sample_decoder_core pvdd_checker u_pvdd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .column_o   (column_o),
  .value_o    (value_o),
  .row_last_o (row_last_o)
);
